### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the checker file lct_chk.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lct assertion failed");

// next-cycle implication
`define LCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lct assertion failed");

`endif

### rtl/core/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Types and constants shared by the LFU cache table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  localparam int CAP_W  = 5;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_DATA = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_USE,
    UPD_INSERT
  } upd_mode_e;

  typedef struct packed {
    logic      scan_start;
    logic      scan_vld;
    logic      upd_vld;
    logic      commit;
    upd_mode_e mode;
  } lct_ctrl_t;

  typedef struct packed {
    logic hit;
    logic victim;
    logic free;
    logic full;
  } lct_stat_t;

endpackage

`default_nettype wire

### rtl/core/lct_ram.sv
// ----------------------------------------------------------------------------
// lct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/lct_unit.sv
// ----------------------------------------------------------------------------
// lct_unit
// Shared compare and rewrite unit: key match, victim and free-slot search on
// the scan pass, rank, count, key and value rewrite on the update pass; holds valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_unit #(
  parameter int DEPTH       = 16,
  parameter int COUNT_WIDTH = 16,
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int RANK_W     = IDX_W,
  localparam int ROW_W      = lct_pkg::KEY_W + lct_pkg::DATA_W + COUNT_WIDTH + RANK_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lct_pkg::lct_ctrl_t          ctrl_i,
  input  wire logic [lct_pkg::CAP_W-1:0]   cap_i,
  input  wire logic                        func_i,
  input  wire logic [lct_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lct_pkg::DATA_W-1:0]  value_i,
  input  wire logic [IDX_W-1:0]            idx_i,
  input  wire logic [ROW_W-1:0]            rd_row_i,
  output lct_pkg::lct_stat_t               stat_o,
  output logic      [lct_pkg::DATA_W-1:0]  hit_value_o,
  output logic                             we_o,
  output logic      [ROW_W-1:0]            wr_row_o
);

  import lct_pkg::*;

  logic [DEPTH-1:0]       valid_q, valid_d;
  logic [CAP_W-1:0]       occ_q, occ_d;
  logic                   hit_q, hit_d;
  logic                   vic_q, vic_d;
  logic                   free_q, free_d;
  upd_mode_e              mode_q, mode_d;
  logic                   evict_q, evict_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [RANK_W-1:0]      hit_rank_q, hit_rank_d;
  logic [DATA_W-1:0]      hit_value_q, hit_value_d;
  logic [IDX_W-1:0]       vic_idx_q, vic_idx_d;
  logic [COUNT_WIDTH-1:0] vic_cnt_q, vic_cnt_d;
  logic [RANK_W-1:0]      vic_rank_q, vic_rank_d;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;
  logic [IDX_W-1:0]       tgt_q, tgt_d;

  logic [RANK_W-1:0]      row_rank;
  logic [COUNT_WIDTH-1:0] row_cnt;
  logic [DATA_W-1:0]      row_val;
  logic [KEY_W-1:0]       row_key;
  logic                   row_vld;
  logic                   full;
  logic                   evict;
  logic [IDX_W-1:0]       slot;

  logic [RANK_W-1:0]      new_rank;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [DATA_W-1:0]      new_val;
  logic [KEY_W-1:0]       new_key;

  assign row_rank = rd_row_i[RANK_W-1:0];
  assign row_cnt  = rd_row_i[RANK_W +: COUNT_WIDTH];
  assign row_val  = rd_row_i[RANK_W+COUNT_WIDTH +: DATA_W];
  assign row_key  = rd_row_i[RANK_W+COUNT_WIDTH+DATA_W +: KEY_W];
  assign row_vld  = valid_q[idx_i];

  assign full  = (occ_q >= cap_i);
  assign evict = full && vic_q;
  assign slot  = (free_q && (!evict || (free_idx_q < vic_idx_q))) ? free_idx_q : vic_idx_q;

  assign stat_o      = '{hit: hit_q, victim: vic_q, free: free_q, full: full};
  assign hit_value_o = hit_value_q;

  // search pass and commit
  always_comb begin
    valid_d     = valid_q;
    occ_d       = occ_q;
    hit_d       = hit_q;
    vic_d       = vic_q;
    free_d      = free_q;
    mode_d      = mode_q;
    evict_d     = evict_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    hit_value_d = hit_value_q;
    vic_idx_d   = vic_idx_q;
    vic_cnt_d   = vic_cnt_q;
    vic_rank_d  = vic_rank_q;
    free_idx_d  = free_idx_q;
    tgt_d       = tgt_q;

    if (ctrl_i.scan_start) begin
      hit_d  = 1'b0;
      vic_d  = 1'b0;
      free_d = 1'b0;
    end else if (ctrl_i.scan_vld) begin
      if (row_vld && (row_key == key_i) && !hit_q) begin
        hit_d       = 1'b1;
        hit_idx_d   = idx_i;
        hit_rank_d  = row_rank;
        hit_value_d = row_val;
      end
      if (row_vld && (!vic_q || (row_cnt < vic_cnt_q) ||
                      ((row_cnt == vic_cnt_q) && (row_rank > vic_rank_q)))) begin
        vic_d      = 1'b1;
        vic_idx_d  = idx_i;
        vic_cnt_d  = row_cnt;
        vic_rank_d = row_rank;
      end
      if (!row_vld && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = idx_i;
      end
    end

    if (ctrl_i.commit) begin
      mode_d  = ctrl_i.mode;
      evict_d = (ctrl_i.mode == UPD_INSERT) && evict;
      tgt_d   = (ctrl_i.mode == UPD_INSERT) ? slot : hit_idx_q;
      if (ctrl_i.mode == UPD_INSERT) begin
        if (evict) begin
          valid_d[vic_idx_q] = 1'b0;
        end
        valid_d[slot] = 1'b1;
        occ_d = occ_q + CAP_W'(1) - CAP_W'(evict);
      end
    end
  end

  // update pass
  always_comb begin
    new_key  = row_key;
    new_val  = row_val;
    new_cnt  = row_cnt;
    new_rank = row_rank;
    if (idx_i == tgt_q) begin
      new_rank = '0;
      if (mode_q == UPD_INSERT) begin
        new_key = key_i;
        new_val = value_i;
        new_cnt = COUNT_WIDTH'(1);
      end else begin
        if (func_i == FUNC_PUT) begin
          new_val = value_i;
        end
        if (row_cnt != {COUNT_WIDTH{1'b1}}) begin
          new_cnt = row_cnt + COUNT_WIDTH'(1);
        end
      end
    end else if (mode_q == UPD_INSERT) begin
      new_rank = row_rank + RANK_W'(1) - RANK_W'(evict_q && (row_rank > vic_rank_q));
    end else if (row_rank < hit_rank_q) begin
      new_rank = row_rank + RANK_W'(1);
    end
  end

  assign we_o     = ctrl_i.upd_vld && ((idx_i == tgt_q) || row_vld);
  assign wr_row_o = {new_key, new_val, new_cnt, new_rank};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      hit_q   <= 1'b0;
      vic_q   <= 1'b0;
      free_q  <= 1'b0;
      mode_q  <= UPD_NONE;
      evict_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      hit_q   <= hit_d;
      vic_q   <= vic_d;
      free_q  <= free_d;
      mode_q  <= mode_d;
      evict_q <= evict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    hit_rank_q  <= hit_rank_d;
    hit_value_q <= hit_value_d;
    vic_idx_q   <= vic_idx_d;
    vic_cnt_q   <= vic_cnt_d;
    vic_rank_q  <= vic_rank_d;
    free_idx_q  <= free_idx_d;
    tgt_q       <= tgt_d;
  end

endmodule

`default_nettype wire

### rtl/core/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// Sequencer: handshakes, capacity register, row counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_ctrl #(
  parameter int DEPTH  = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        func_i,
  input  wire logic [lct_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lct_pkg::DATA_W-1:0]  value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             found_o,
  output logic      [lct_pkg::DATA_W-1:0]  data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lct_pkg::CAP_W-1:0]   cfg_data_i,
  output lct_pkg::lct_ctrl_t               ctrl_o,
  output logic      [lct_pkg::CAP_W-1:0]   cap_o,
  output logic                             func_o,
  output logic      [lct_pkg::KEY_W-1:0]   key_o,
  output logic      [lct_pkg::DATA_W-1:0]  value_o,
  output logic                             re_o,
  output logic      [IDX_W-1:0]            raddr_o,
  output logic      [IDX_W-1:0]            idx_o,
  input  wire lct_pkg::lct_stat_t          stat_i,
  input  wire logic [lct_pkg::DATA_W-1:0]  hit_value_i
);

  import lct_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pipe_vld_q, pipe_vld_d;
  logic [IDX_W-1:0]  pipe_idx_q, pipe_idx_d;
  logic [CAP_W-1:0]  cap_q;
  logic              func_q, func_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              issue;
  upd_mode_e         mode;

  assign cap_o       = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
  assign cfg_ready_o = 1'b1;
  assign issue       = (cnt_q < CNT_W'(DEPTH));
  assign raddr_o     = cnt_q[IDX_W-1:0];
  assign idx_o       = pipe_idx_q;
  assign func_o      = func_q;
  assign key_o       = key_q;
  assign value_o     = value_q;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign data_o      = data_q;

  always_comb begin
    if (func_q == FUNC_GET) begin
      mode = stat_i.hit ? UPD_USE : UPD_NONE;
    end else if (cap_o == '0) begin
      mode = UPD_NONE;
    end else if (stat_i.hit) begin
      mode = UPD_USE;
    end else if ((stat_i.full && stat_i.victim) || stat_i.free) begin
      mode = UPD_INSERT;
    end else begin
      mode = UPD_NONE;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pipe_vld_d  = 1'b0;
    pipe_idx_d  = cnt_q[IDX_W-1:0];
    func_d      = func_q;
    key_d       = key_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    data_d      = data_q;
    re_o        = 1'b0;
    ctrl_o      = '{scan_start: 1'b0, scan_vld: 1'b0, upd_vld: 1'b0,
                    commit: 1'b0, mode: UPD_NONE};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d            = func_i;
          key_d             = key_i;
          value_d           = value_i;
          cnt_d             = '0;
          ctrl_o.scan_start = 1'b1;
          state_d           = ST_SCAN;
        end
      end
      ST_SCAN: begin
        re_o            = issue;
        pipe_vld_d      = issue;
        ctrl_o.scan_vld = pipe_vld_q;
        if (issue) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctrl_o.commit = 1'b1;
        ctrl_o.mode   = mode;
        cnt_d         = '0;
        state_d       = (mode == UPD_NONE) ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        re_o           = issue;
        pipe_vld_d     = issue;
        ctrl_o.upd_vld = pipe_vld_q;
        if (issue) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = stat_i.hit;
          if (func_q == FUNC_GET) begin
            data_d = stat_i.hit ? hit_value_i : MISS_DATA;
          end else begin
            data_d = value_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pipe_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pipe_vld_q  <= pipe_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    func_q     <= func_d;
    key_q      <= key_d;
    value_q    <= value_d;
    found_q    <= found_d;
    data_q     <= data_d;
  end

endmodule

`default_nettype wire

### rtl/core/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value cache, least-frequently-used replacement with
// oldest-touch tiebreak; one table row per cycle through a shared unit.
//
//   port group  dir   handshake              word
//   in          in    in_valid_i/in_stall_o  func_i, key_i, value_i
//   out         out   out_valid_o/out_stall_i found_o, data_o
//   cfg         in    cfg_valid_i/cfg_ready_o cfg_data_i (capacity)
//
// DEPTH = min(CAPACITY, 31) rows. A get miss or a put at capacity zero takes
// the search pass only; a hit or an insert takes a search pass and a rewrite
// pass, each one row per cycle through the single read port of the entry RAM.
// Reset clears valid bits and occupancy at once; no clearing pass.
// A finished result waits in the output register while the next word is
// taken; a stalled result holds the following word in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table #(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        func_i,
  input  wire logic [lct_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lct_pkg::DATA_W-1:0]  value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             found_o,
  output logic      [lct_pkg::DATA_W-1:0]  data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lct_pkg::CAP_W-1:0]   cfg_data_i
);

  import lct_pkg::*;

  localparam int DEPTH  = (CAPACITY < 31) ? CAPACITY : 31;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = KEY_W + DATA_W + COUNT_WIDTH + IDX_W;

  lct_ctrl_t         ctrl;
  lct_stat_t         stat;
  logic [CAP_W-1:0]  cap;
  logic              func;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] value;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] hit_value;
  logic              we;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;

  lct_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .data_o      (data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ctrl_o      (ctrl),
    .cap_o       (cap),
    .func_o      (func),
    .key_o       (key),
    .value_o     (value),
    .re_o        (re),
    .raddr_o     (raddr),
    .idx_o       (idx),
    .stat_i      (stat),
    .hit_value_i (hit_value)
  );

  lct_unit #(
    .DEPTH       (DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cap_i       (cap),
    .func_i      (func),
    .key_i       (key),
    .value_i     (value),
    .idx_i       (idx),
    .rd_row_i    (rd_row),
    .stat_o      (stat),
    .hit_value_o (hit_value),
    .we_o        (we),
    .wr_row_o    (wr_row)
  );

  lct_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wr_row),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_row)
  );

endmodule

`default_nettype wire

### rtl/core/lct_chk.sv
// ----------------------------------------------------------------------------
// lct_chk
// Port-level checker for the LFU cache table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lct_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        found_o,
  input wire logic [lct_pkg::DATA_W-1:0]  data_o
);

  import lct_pkg::*;

  `LCT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(found_o) && $stable(data_o))

  `LCT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o)

  `LCT_ASSERT_IMP(a_ready_on_result, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

endmodule

bind lfu_cache_table lct_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .data_o      (data_o)
);

`default_nettype wire
